FILE: src/day_number_to_calendar_date_top_defines.svh
// Assertion helpers for the top-level design file.
`ifndef DAY_NUMBER_TO_CALENDAR_DATE_TOP_DEFINES_SVH
`define DAY_NUMBER_TO_CALENDAR_DATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge while reset is released.
`define DNCD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
// Check a property on every rising clock edge, reset included.
`define DNCD_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("%m: assertion failed");
`else
`define DNCD_ASSERT(lbl, clk, rst_n, prop)
`define DNCD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: src/dncd_pkg.sv
package dncd_pkg;

	// Scale of second_scaled: seconds times 2^FRACTION_BITS, from 16 to 32.
	localparam int FRACTION_BITS = 32;

	// Supported modified Julian day numbers.
	localparam logic signed [22:0] DAY_LOW  = -23'sd2400000;
	localparam logic signed [22:0] DAY_HIGH = 23'sd2973483;

	// Julian day number offset and the first Gregorian Julian day number.
	localparam logic signed [23:0] JD_OFFSET = 24'sd2400001;
	localparam logic [22:0]        SWITCH_JD = 23'd2299161;

	// 4*A - 7468865 written directly in terms of the modified day number.
	localparam logic signed [24:0] B_BIAS = 25'sd2131139;

	// Exact division by constants through rounded-up reciprocals.
	localparam int B_SHIFT = 43;
	localparam logic [25:0] B_MUL =
		26'(((64'd1 << B_SHIFT) + 64'd146096) / 64'd146097);
	localparam int D_SHIFT = 40;
	localparam logic [27:0] D_MUL =
		28'(((64'd1 << D_SHIFT) + 64'd7304) / 64'd7305);
	// Month index F = floor(10000 * (C - E) / 306001) in one product.
	localparam int F_SHIFT = 32;
	localparam logic [27:0] F_MUL =
		28'(((64'd10000 << F_SHIFT) + 64'd306000) / 64'd306001);

	localparam logic [22:0] C_JULIAN_ADD    = 23'd1524;
	localparam logic [22:0] C_GREGORIAN_ADD = 23'd1525;
	localparam logic [26:0] D_BIAS          = 27'd2442;
	localparam logic signed [15:0] YEAR_BIAS = 16'sd4715;

	// Result fields of the date path.
	typedef struct packed {
		logic [14:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic        range_error;
	} date_t;

	// Result fields of the time-of-day path.
	typedef struct packed {
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [37:0] second_scaled;
	} tod_t;

	// Days before month index f: floor(306001 * f / 10000).
	function automatic logic [8:0] month_start(input logic [3:0] f);
		logic [8:0] days;
		case (f)
			4'd0:    days = 9'd0;
			4'd1:    days = 9'd30;
			4'd2:    days = 9'd61;
			4'd3:    days = 9'd91;
			4'd4:    days = 9'd122;
			4'd5:    days = 9'd153;
			4'd6:    days = 9'd183;
			4'd7:    days = 9'd214;
			4'd8:    days = 9'd244;
			4'd9:    days = 9'd275;
			4'd10:   days = 9'd306;
			4'd11:   days = 9'd336;
			4'd12:   days = 9'd367;
			4'd13:   days = 9'd397;
			4'd14:   days = 9'd428;
			default: days = 9'd459;
		endcase
		return days;
	endfunction

endpackage

FILE: src/dncd_date_pipe.sv
module dncd_date_pipe (
	input  logic               clk,
	input  logic signed [22:0] day_number,
	output dncd_pkg::date_t    date
);
	import dncd_pkg::*;

	// Stage 1: range check, Julian day number and the century term operand.
	logic [22:0] a_s1;
	logic        greg_s1;
	logic        err_s1;
	logic [24:0] xb_s1;
	logic signed [23:0] jd_full;
	logic signed [24:0] xb_full;

	always_comb begin
		jd_full = $signed({day_number[22], day_number}) + JD_OFFSET;
		xb_full = $signed({day_number, 2'b00}) + B_BIAS;
	end

	always_ff @(posedge clk) begin
		a_s1    <= jd_full[22:0];
		greg_s1 <= (jd_full[22:0] >= SWITCH_JD);
		err_s1  <= (day_number < DAY_LOW) || (day_number > DAY_HIGH);
		xb_s1   <= xb_full;
	end

	// Stage 2: century count B as a reciprocal product.
	logic [50:0] pb_s2;
	logic [22:0] a_s2;
	logic        greg_s2;
	logic        err_s2;

	always_ff @(posedge clk) begin
		pb_s2   <= 51'(xb_s1) * 51'(B_MUL);
		a_s2    <= a_s1;
		greg_s2 <= greg_s1;
		err_s2  <= err_s1;
	end

	// Stage 3: calendar-corrected day count C and the year operand 20*C - 2442.
	logic [6:0]  b;
	logic [22:0] c_next;
	logic [22:0] c_s3;
	logic [26:0] xd_s3;
	logic        err_s3;

	always_comb begin
		b = pb_s2[B_SHIFT +: 7];
		if (greg_s2) begin
			c_next = a_s2 + 23'(b) - 23'(b >> 2) + C_GREGORIAN_ADD;
		end else begin
			c_next = a_s2 + C_JULIAN_ADD;
		end
	end

	always_ff @(posedge clk) begin
		c_s3   <= c_next;
		xd_s3  <= 27'({c_next, 4'b0000}) + 27'({c_next, 2'b00}) - D_BIAS;
		err_s3 <= err_s2;
	end

	// Stage 4: year count D as a reciprocal product.
	logic [54:0] pd_s4;
	logic [22:0] c_s4;
	logic        err_s4;

	always_ff @(posedge clk) begin
		pd_s4  <= 55'(xd_s3) * 55'(D_MUL);
		c_s4   <= c_s3;
		err_s4 <= err_s3;
	end

	// Stage 5: days in the year so far, C - E.
	logic [13:0] d;
	logic [22:0] e;
	logic [22:0] ce_full;
	logic [13:0] d_s5;
	logic [8:0]  ce_s5;
	logic        err_s5;

	always_comb begin
		d       = pd_s4[D_SHIFT +: 14];
		e       = 23'(d) * 23'd365 + 23'(d >> 2);
		ce_full = c_s4 - e;
	end

	always_ff @(posedge clk) begin
		d_s5   <= d;
		ce_s5  <= ce_full[8:0];
		err_s5 <= err_s4;
	end

	// Stage 6: month index F as a reciprocal product.
	logic [36:0] pf_s6;
	logic [13:0] d_s6;
	logic [8:0]  ce_s6;
	logic        err_s6;

	always_ff @(posedge clk) begin
		pf_s6  <= 37'(ce_s5) * 37'(F_MUL);
		d_s6   <= d_s5;
		ce_s6  <= ce_s5;
		err_s6 <= err_s5;
	end

	// Stage 7: day, month and year; a day out of range gives a zero date.
	logic [3:0]  f;
	logic [3:0]  month_c;
	logic [8:0]  day_c;
	logic signed [15:0] year_c;
	date_t       date_s7;

	always_comb begin
		f     = pf_s6[F_SHIFT +: 4];
		day_c = ce_s6 - month_start(f);
		if (f >= 4'd14) begin
			month_c = f - 4'd13;
		end else begin
			month_c = f - 4'd1;
		end
		year_c = $signed({2'b00, d_s6}) - YEAR_BIAS - $signed({15'd0, (month_c >= 4'd3)});
	end

	always_ff @(posedge clk) begin
		date_s7.range_error <= err_s6;
		if (err_s6) begin
			date_s7.year         <= '0;
			date_s7.month        <= '0;
			date_s7.day_of_month <= '0;
		end else begin
			date_s7.year         <= year_c[14:0];
			date_s7.month        <= month_c;
			date_s7.day_of_month <= day_c[4:0];
		end
	end

	assign date = date_s7;

endmodule

FILE: src/dncd_time_pipe.sv
module dncd_time_pipe (
	input  logic          clk,
	input  logic [31:0]   day_fraction,
	output dncd_pkg::tod_t tod
);
	import dncd_pkg::*;

	// Stages 1 to 4: the fraction waits so that the time lines up with the date.
	logic [31:0] frac_s1;
	logic [31:0] frac_s2;
	logic [31:0] frac_s3;
	logic [31:0] frac_s4;

	always_ff @(posedge clk) begin
		frac_s1 <= day_fraction;
		frac_s2 <= frac_s1;
		frac_s3 <= frac_s2;
		frac_s4 <= frac_s3;
	end

	// Stage 5: hours as the integer part of 24 times the fraction.
	logic [36:0] t1_s5;

	always_ff @(posedge clk) begin
		t1_s5 <= 37'(frac_s4) * 37'd24;
	end

	// Stage 6: minutes from the remainder of the hour.
	logic [4:0]  hour_s6;
	logic [37:0] t2_s6;

	always_ff @(posedge clk) begin
		hour_s6 <= t1_s5[36:32];
		t2_s6   <= 38'(t1_s5[31:0]) * 38'd60;
	end

	// Stage 7: scaled seconds from the remainder of the minute.
	logic [37:0] t3;
	tod_t        tod_s7;

	always_comb begin
		t3 = 38'(t2_s6[31:0]) * 38'd60;
	end

	always_ff @(posedge clk) begin
		tod_s7.hour          <= hour_s6;
		tod_s7.minute        <= t2_s6[37:32];
		tod_s7.second_scaled <= t3 >> (32 - FRACTION_BITS);
	end

	assign tod = tod_s7;

endmodule

FILE: src/day_number_to_calendar_date_top.sv
// Each transaction taken on start gives a done strobe from the last pipeline stage.
// Throughput: one transaction per cycle; busy stays low, so start is always taken.
// The rate is set by the seven-stage pipeline, with at most one constant multiplier
// per path in any stage.
// Reset clears only the valid bits of the pipeline; no done strobe follows reset.
// The receiver cannot stall, and each result is shown for exactly one cycle.
`include "day_number_to_calendar_date_top_defines.svh"

module day_number_to_calendar_date_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [22:0] day_number,
	input  logic [31:0]        day_fraction,
	output logic               done,
	output logic signed [14:0] year,
	output logic [3:0]         month,
	output logic [4:0]         day_of_month,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [37:0]        second_scaled,
	output logic               range_error
);
	import dncd_pkg::*;

	// The pipeline always advances, so a transaction can be taken every cycle.
	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Valid bits that travel alongside the data stages.
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;
	logic valid_s6;
	logic valid_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Date and time-of-day paths run side by side with equal depth.
	date_t date;
	tod_t  tod;

	dncd_date_pipe u_date (
		.clk        (clk),
		.day_number (day_number),
		.date       (date)
	);

	dncd_time_pipe u_time (
		.clk          (clk),
		.day_fraction (day_fraction),
		.tod          (tod)
	);

	// Result ports come straight from the last stage registers.
	assign done          = valid_s7;
	assign year          = $signed(date.year);
	assign month         = date.month;
	assign day_of_month  = date.day_of_month;
	assign range_error   = date.range_error;
	assign hour          = tod.hour;
	assign minute        = tod.minute;
	assign second_scaled = tod.second_scaled;

	// Every accepted transaction produces its done strobe.
	`DNCD_ASSERT(a_latency, clk, arst_n, accept |-> ##7 done)
	// A day out of range clears the whole date.
	`DNCD_ASSERT(a_err_zero, clk, arst_n,
		(done && range_error) |-> (year == 15'sd0 && month == 4'd0 && day_of_month == 5'd0))
	// A supported day gives a real month and day.
	`DNCD_ASSERT(a_date_ok, clk, arst_n,
		(done && !range_error) |-> (month >= 4'd1 && month <= 4'd12 &&
		day_of_month >= 5'd1 && day_of_month <= 5'd31))
	// Hour and minute stay within a day and an hour.
	`DNCD_ASSERT(a_tod_ok, clk, arst_n, done |-> (hour <= 5'd23 && minute <= 6'd59))
	// The pipeline never refuses a transaction.
	`DNCD_ASSERT_ALWAYS(a_never_busy, clk, !busy)

endmodule
